@@ rtl/prc_pkg.sv @@
`timescale 1ns / 1ps
package prc_pkg;

  localparam int COORD_W = 32;
  localparam int T_FRAC  = 24;
  localparam int DW      = COORD_W + 1;
  localparam int UW      = T_FRAC + 1;
  localparam int QW      = T_FRAC + 2;
  localparam int TW      = T_FRAC + 3;
  localparam int AW      = COORD_W + T_FRAC + 2;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_BOTTOM = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      is_break;
  } prc_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      gap_marker;
    logic                      run_last;
  } prc_out_t;

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } prc_op_t;

  typedef struct packed {
    logic    start;
    prc_op_t op;
  } prc_req_t;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

@@ rtl/prc_mdu.sv @@
`timescale 1ns / 1ps
module prc_mdu import prc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  prc_req_t       req_i,
  input  logic [DW-1:0]  a_i,
  input  logic [DW-1:0]  b_i,
  input  logic [UW-1:0]  u_i,
  output logic           done_o,
  output logic [QW-1:0]  quo_o,
  output logic [DW-1:0]  prod_o
);

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001,
    M_DPRE = 7'b0000010,
    M_DINT = 7'b0000100,
    M_DIV  = 7'b0001000,
    M_MUL  = 7'b0010000,
    M_RND  = 7'b0100000,
    M_DONE = 7'b1000000
  } mdu_st_t;

  mdu_st_t         st_r, st_nxt;
  logic [AW-1:0]   acc_r, acc_nxt;
  logic [QW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [UW-1:0]   u_r, u_nxt;
  logic [4:0]      cnt_r, cnt_nxt;

  logic [AW-1:0]   add_a, add_b;
  logic            sub;
  logic [AW:0]     sum;
  logic            ge;

  // single shared adder / subtractor
  always_comb begin
    add_a = '0;
    add_b = '0;
    sub   = 1'b1;
    case (st_r)
      M_DPRE: begin
        add_a = AW'(a_r);
        add_b = AW'(b_r) << 1;
      end
      M_DINT: begin
        add_a = AW'(a_r);
        add_b = AW'(b_r);
      end
      M_DIV: begin
        add_a = acc_r << 1;
        add_b = AW'(b_r);
      end
      M_MUL: begin
        add_a = acc_r << 1;
        add_b = u_r[UW-1] ? AW'(a_r) : '0;
        sub   = 1'b0;
      end
      M_RND: begin
        add_a = acc_r;
        add_b = AW'(1) << (T_FRAC - 1);
        sub   = 1'b0;
      end
      default: begin
        add_a = '0;
      end
    endcase
    sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + (AW+1)'(sub);
    ge  = sum[AW];
  end

  always_comb begin
    st_nxt  = st_r;
    acc_nxt = acc_r;
    quo_nxt = quo_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    u_nxt   = u_r;
    cnt_nxt = cnt_r;
    case (st_r)
      M_IDLE: begin
        if (req_i.start) begin
          a_nxt   = a_i;
          b_nxt   = b_i;
          u_nxt   = u_i;
          acc_nxt = '0;
          cnt_nxt = '0;
          st_nxt  = (req_i.op == OP_MUL) ? M_MUL : M_DPRE;
        end
      end
      M_DPRE: begin
        if (ge) begin
          quo_nxt = QW'(2) << T_FRAC;
          st_nxt  = M_DONE;
        end else begin
          st_nxt = M_DINT;
        end
      end
      M_DINT: begin
        if (ge) begin
          acc_nxt = sum[AW-1:0];
          quo_nxt = QW'(1);
        end else begin
          acc_nxt = AW'(a_r);
          quo_nxt = '0;
        end
        cnt_nxt = '0;
        st_nxt  = M_DIV;
      end
      M_DIV: begin
        if (ge) begin
          acc_nxt = sum[AW-1:0];
          quo_nxt = {quo_r[QW-2:0], 1'b1};
        end else begin
          acc_nxt = acc_r << 1;
          quo_nxt = {quo_r[QW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(T_FRAC - 1)) st_nxt = M_DONE;
      end
      M_MUL: begin
        acc_nxt = sum[AW-1:0];
        u_nxt   = u_r << 1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(UW - 1)) st_nxt = M_RND;
      end
      M_RND: begin
        acc_nxt = sum[AW-1:0];
        st_nxt  = M_DONE;
      end
      M_DONE: begin
        st_nxt = M_IDLE;
      end
      default: begin
        st_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= M_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    u_r   <= u_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done_o = (st_r == M_DONE);
  assign quo_o  = quo_r;
  assign prod_o = acc_r[T_FRAC +: DW];

endmodule

@@ rtl/polyline_rect_clipper_top.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Handshake            Payload
// in_      in   in_valid/in_ready    prc_in_t  (coord_x, coord_y, is_break)
// out_     out  out_valid/out_ready  prc_out_t (point_x, point_y, gap_marker, run_last)
// cfg_     in   cfg_wr_en            cfg_index, cfg_wdata
//
// A segment holds the input off after its transfer: up to four clip-parameter divisions and
// four end-point multiplies on the one shared shift/add unit, a check of the clipped range
// and up to three output items. A rejected edge or a saturated ratio ends sooner. Items that
// form no segment leave the input ready.
// Synchronous active-low reset clears the sequencers and control registers, not the datapath.
// One output register: the next item is taken while the last point awaits transfer.
module polyline_rect_clipper_top import prc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prc_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prc_out_t            out_data,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [COORD_W-1:0]  cfg_wdata
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EDGE = 9'b000000010,
    S_DIVW = 9'b000000100,
    S_FIN  = 9'b000001000,
    S_MST  = 9'b000010000,
    S_MULW = 9'b000100000,
    S_GAP  = 9'b001000000,
    S_P1   = 9'b010000000,
    S_P2   = 9'b100000000
  } seq_st_t;

  seq_st_t                    st_r, st_nxt;
  logic signed [COORD_W-1:0]  left_r, right_r, bottom_r, top_r;
  logic signed [COORD_W-1:0]  prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [COORD_W-1:0]  start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic                       have_prev_r, have_prev_nxt;
  logic [1:0]                 pcnt_r, pcnt_nxt;
  logic                       any_r, any_nxt;
  logic signed [COORD_W-1:0]  x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic [1:0]                 edge_r, edge_nxt;
  logic signed [TW-1:0]       u1_r, u1_nxt, u2_r, u2_nxt;
  logic [1:0]                 j_r, j_nxt;
  logic [COORD_W-1:0]         pts_r [4];
  logic [COORD_W-1:0]         pts_nxt [4];
  logic                       out_valid_r, out_valid_nxt;
  prc_out_t                   out_data_r, out_data_nxt;

  logic signed [DW-1:0]       dx, dy, p, q, md;
  logic                       p_zero, in_fire, slot_free, load;
  prc_out_t                   ld_data;
  logic signed [TW-1:0]       t_mag, t, mu;
  logic [COORD_W-1:0]         mbase, newc;
  prc_req_t                   req;
  logic [DW-1:0]              ua;
  logic                       mdone;
  logic [QW-1:0]              quo;
  logic [DW-1:0]              prod;

  assign dx = DW'(x2_r) - DW'(x1_r);
  assign dy = DW'(y2_r) - DW'(y1_r);

  always_comb begin
    case (edge_r)
      2'd0: begin
        p = -dx;
        q = DW'(x1_r) - DW'(left_r);
      end
      2'd1: begin
        p = dx;
        q = DW'(right_r) - DW'(x1_r);
      end
      2'd2: begin
        p = -dy;
        q = DW'(y1_r) - DW'(bottom_r);
      end
      default: begin
        p = dy;
        q = DW'(top_r) - DW'(y1_r);
      end
    endcase
  end

  assign p_zero = (p == '0);
  assign t_mag  = $signed({1'b0, quo});
  assign t      = (q[DW-1] ^ p[DW-1]) ? -t_mag : t_mag;

  assign md    = j_r[0] ? dy : dx;
  assign mbase = j_r[0] ? y1_r : x1_r;
  assign mu    = j_r[1] ? u2_r : u1_r;
  assign newc  = md[DW-1] ? (mbase - prod[COORD_W-1:0]) : (mbase + prod[COORD_W-1:0]);

  assign req.start = ((st_r == S_EDGE) && !p_zero) || (st_r == S_MST);
  assign req.op    = (st_r == S_MST) ? OP_MUL : OP_DIV;
  assign ua        = (st_r == S_MST) ? mag(md) : mag(q);

  prc_mdu u_mdu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (req),
    .a_i    (ua),
    .b_i    (mag(p)),
    .u_i    (mu[UW-1:0]),
    .done_o (mdone),
    .quo_o  (quo),
    .prod_o (prod)
  );

  assign in_ready  = (st_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    st_nxt        = st_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    have_prev_nxt = have_prev_r;
    pcnt_nxt      = pcnt_r;
    any_nxt       = any_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    edge_nxt      = edge_r;
    u1_nxt        = u1_r;
    u2_nxt        = u2_r;
    j_nxt         = j_r;
    pts_nxt       = pts_r;
    load          = 1'b0;
    ld_data       = '0;
    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          x1_nxt   = prev_x_r;
          y1_nxt   = prev_y_r;
          edge_nxt = 2'd0;
          u1_nxt   = '0;
          u2_nxt   = TW'(1) << T_FRAC;
          if (in_data.is_break) begin
            x2_nxt = start_x_r;
            y2_nxt = start_y_r;
            if (pcnt_r == 2'd2 && !(prev_x_r == start_x_r && prev_y_r == start_y_r))
              st_nxt = S_EDGE;
            have_prev_nxt = 1'b0;
            pcnt_nxt      = 2'd0;
          end else begin
            x2_nxt = in_data.coord_x;
            y2_nxt = in_data.coord_y;
            if (have_prev_r) st_nxt = S_EDGE;
            prev_x_nxt    = in_data.coord_x;
            prev_y_nxt    = in_data.coord_y;
            have_prev_nxt = 1'b1;
            if (pcnt_r == 2'd0) begin
              start_x_nxt = in_data.coord_x;
              start_y_nxt = in_data.coord_y;
            end
            if (pcnt_r != 2'd2) pcnt_nxt = pcnt_r + 2'd1;
          end
        end
      end
      S_EDGE: begin
        if (p_zero) begin
          if (q[DW-1]) st_nxt = S_IDLE;
          else if (edge_r == 2'd3) st_nxt = S_FIN;
          else edge_nxt = edge_r + 2'd1;
        end else begin
          st_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        if (mdone) begin
          if ((p[DW-1] && t > u2_r) || (!p[DW-1] && t < u1_r)) begin
            st_nxt = S_IDLE;
          end else begin
            if (p[DW-1] && t > u1_r) u1_nxt = t;
            if (!p[DW-1] && t < u2_r) u2_nxt = t;
            if (edge_r == 2'd3) begin
              st_nxt = S_FIN;
            end else begin
              edge_nxt = edge_r + 2'd1;
              st_nxt   = S_EDGE;
            end
          end
        end
      end
      S_FIN: begin
        if (u1_r > u2_r) begin
          st_nxt = S_IDLE;
        end else begin
          j_nxt  = 2'd0;
          st_nxt = S_MST;
        end
      end
      S_MST: begin
        st_nxt = S_MULW;
      end
      S_MULW: begin
        if (mdone) begin
          pts_nxt[j_r] = newc;
          if (j_r == 2'd3) begin
            st_nxt = any_r ? S_GAP : S_P1;
          end else begin
            j_nxt  = j_r + 2'd1;
            st_nxt = S_MST;
          end
        end
      end
      S_GAP: begin
        if (slot_free) begin
          load               = 1'b1;
          ld_data.gap_marker = 1'b1;
          st_nxt             = S_P1;
        end
      end
      S_P1: begin
        if (slot_free) begin
          load            = 1'b1;
          ld_data.point_x = pts_r[0];
          ld_data.point_y = pts_r[1];
          st_nxt          = S_P2;
        end
      end
      S_P2: begin
        if (slot_free) begin
          load             = 1'b1;
          ld_data.point_x  = pts_r[2];
          ld_data.point_y  = pts_r[3];
          ld_data.run_last = 1'b1;
          any_nxt          = 1'b1;
          st_nxt           = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_data_nxt  = load ? ld_data : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      bottom_r    <= '0;
      top_r       <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      have_prev_r <= 1'b0;
      pcnt_r      <= 2'd0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      have_prev_r <= have_prev_nxt;
      pcnt_r      <= pcnt_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LEFT:   left_r   <= cfg_wdata;
          REG_RIGHT:  right_r  <= cfg_wdata;
          REG_BOTTOM: bottom_r <= cfg_wdata;
          REG_TOP:    top_r    <= cfg_wdata;
          default:    left_r   <= left_r;
        endcase
      end
    end
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    x2_r       <= x2_nxt;
    y2_r       <= y2_nxt;
    edge_r     <= edge_nxt;
    u1_r       <= u1_nxt;
    u2_r       <= u2_nxt;
    j_r        <= j_nxt;
    pts_r      <= pts_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/prc_checker.sv @@
`timescale 1ns / 1ps
module prc_checker import prc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input prc_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // gap markers carry no point and never close a run
  a_gap_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.gap_marker |->
      !out_data.run_last && out_data.point_x == '0 && out_data.point_y == '0)
    else $error("malformed gap marker");

  // a gap transfer is followed at once by a start point
  a_gap_then_pt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.gap_marker |=> out_valid && !out_data.gap_marker)
    else $error("gap marker not followed by a point");

  // no input taken while a run is still being delivered
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_last |-> !in_ready)
    else $error("input ready in the middle of a run");

endmodule

bind polyline_rect_clipper_top prc_checker u_prc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
